/* sv/itf_pkg.sv */
// ----------------------------------------------------------------------------
// Integer text formatter package
// Kind codes, radix codes, character constants and the digit-to-ASCII helper
// shared by the formatter and its digit unit.
// ----------------------------------------------------------------------------
package itf_pkg;

	// Widest field that is ever padded out.
	localparam int MAX_WIDTH = 63;

	// Deepest digit buffer: 32 bits in octal give 11 digits.
	localparam int DIG_DEPTH = 12;
	localparam int DIG_IDX_W = $clog2(DIG_DEPTH);

	// Conversion kinds as they arrive on the kind port.
	localparam logic [2:0] KIND_SDEC = 3'd0;
	localparam logic [2:0] KIND_UDEC = 3'd1;
	localparam logic [2:0] KIND_OCT  = 3'd2;
	localparam logic [2:0] KIND_HEXL = 3'd3;
	localparam logic [2:0] KIND_HEXU = 3'd4;

	// Radix selection for the digit unit.
	localparam logic [1:0] RADIX_DEC = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_HEX = 2'd2;

	// ASCII characters used in the field.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_LOWER_A = 8'h61;

	// Reciprocal of ten, scaled by two to the 35th, for the decimal step.
	localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT = 35;

	// Radix control handed from the sequencer to the digit unit.
	typedef struct packed {
		logic [1:0] radix;
		logic       upper;
	} radix_ctrl_t;

	// Maps a digit value of 0 to 15 onto its ASCII character.
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] dv;
		dv = {4'd0, d};
		if (d < 4'd10) begin
			digit_char = CH_ZERO + dv;
		end else if (upper) begin
			digit_char = CH_UPPER_A + dv - 8'd10;
		end else begin
			digit_char = CH_LOWER_A + dv - 8'd10;
		end
	endfunction

endpackage

/* sv/itf_digit_unit.sv */
// ----------------------------------------------------------------------------
// Integer text formatter digit unit
// Shared radix step: splits the working value into its lowest digit, as an
// ASCII character, and the quotient left for the next step.
// ----------------------------------------------------------------------------
module itf_digit_unit (
	input  logic [31:0]          dividend,
	input  itf_pkg::radix_ctrl_t ctrl,
	output logic [31:0]          quotient,
	output logic [7:0]           digit
);
	import itf_pkg::*;

	logic [63:0] prod;
	logic [31:0] q10;
	logic [31:0] rem10;
	logic [3:0]  dval;

	// Division by ten through the scaled reciprocal; the remainder follows
	// from a shift-and-add multiply of the quotient by ten.
	assign prod  = {32'd0, dividend} * {32'd0, RECIP_10};
	assign q10   = {3'd0, prod[63:RECIP_SHIFT]};
	assign rem10 = dividend - ((q10 << 3) + (q10 << 1));

	// Octal and hex steps are plain shifts.
	always_comb begin
		unique case (ctrl.radix)
			RADIX_OCT: begin
				quotient = dividend >> 3;
				dval     = {1'b0, dividend[2:0]};
			end
			RADIX_HEX: begin
				quotient = dividend >> 4;
				dval     = dividend[3:0];
			end
			default: begin
				quotient = q10;
				dval     = rem10[3:0];
			end
		endcase
	end

	assign digit = digit_char(dval, ctrl.upper);

endmodule

/* sv/integer_text_formatter_top.sv */
// ----------------------------------------------------------------------------
// Integer text formatter
// Turns one integer conversion into a run of ASCII characters with optional
// sign, fill and justification, one character per output word.
// ----------------------------------------------------------------------------
//
// Channel   Handshake          Word
// input     start / busy       kind, value, field_width, zero_fill, left_justify
// output    strobe (no stall)  text_char, last
//
// A conversion is taken when start is high and busy is low. The digit unit
// then produces one digit per cycle (up to 10 decimal, 11 octal, 8 hex), and
// the characters follow at one per cycle. busy stays high from acceptance to
// the last character. Each character is on the outputs for one cycle with
// strobe high; the receiver has no way to hold it off. Reset clears the
// sequencer and the strobe.
//
module integer_text_formatter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  kind,
	input  logic [31:0] value,
	input  logic [5:0]  field_width,
	input  logic        zero_fill,
	input  logic        left_justify,
	output logic        strobe,
	output logic [7:0]  text_char,
	output logic        last
);
	import itf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_PADL = 3'd2;
	localparam logic [2:0] ST_SIGN = 3'd3;
	localparam logic [2:0] ST_DIGS = 3'd4;
	localparam logic [2:0] ST_PADR = 3'd5;

	logic [2:0]           state_q;
	logic [DIG_IDX_W-1:0] nd_q;
	logic [DIG_IDX_W-1:0] idx_q;
	logic [5:0]           pad_q;
	logic                 strobe_q;
	logic                 last_q;
	logic [7:0]           text_char_q;

	logic [31:0]          val_q;
	logic                 neg_q;
	logic                 ljust_q;
	logic                 zfill_q;
	logic [5:0]           width_q;
	radix_ctrl_t          ctrl_q;
	logic [7:0]           dig_q [DIG_DEPTH];

	logic                 accept;
	logic [31:0]          quot;
	logic [7:0]           digit;
	logic [DIG_IDX_W-1:0] nd_next;
	logic [DIG_IDX_W:0]   count;
	logic [5:0]           pad_calc;
	logic [7:0]           fill_char;
	logic [7:0]           char_next;
	radix_ctrl_t          ctrl_in;
	logic [5:0]           width_sat;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Shared digit step.
	itf_digit_unit u_digit (
		.dividend (val_q),
		.ctrl     (ctrl_q),
		.quotient (quot),
		.digit    (digit)
	);

	// Radix and width decode of the incoming word.
	always_comb begin
		ctrl_in.upper = (kind == KIND_HEXU);
		if (kind == KIND_OCT) begin
			ctrl_in.radix = RADIX_OCT;
		end else if (kind == KIND_HEXL || kind == KIND_HEXU) begin
			ctrl_in.radix = RADIX_HEX;
		end else begin
			ctrl_in.radix = RADIX_DEC;
		end
		width_sat = (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;
	end

	// Character count and padding once the final digit is known.
	assign nd_next  = nd_q + 1'b1;
	assign count    = {1'b0, nd_next} + {{DIG_IDX_W{1'b0}}, neg_q};
	assign pad_calc = (width_q > 6'(count)) ? (width_q - 6'(count)) : 6'd0;
	assign fill_char = zfill_q ? CH_ZERO : CH_SPACE;

	// Character for the current output cycle.
	always_comb begin
		unique case (state_q)
			ST_SIGN: char_next = CH_MINUS;
			ST_DIGS: char_next = dig_q[idx_q - 1'b1];
			default: char_next = fill_char;
		endcase
	end

	// Sequencer: digit extraction, then left fill, sign, digits, right fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nd_q     <= '0;
			idx_q    <= '0;
			pad_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						nd_q    <= '0;
					end
				end
				ST_CONV: begin
					nd_q <= nd_next;
					if (quot == 32'd0) begin
						idx_q <= nd_next;
						pad_q <= pad_calc;
						if (!ljust_q && pad_calc != 6'd0) begin
							state_q <= ST_PADL;
						end else if (neg_q) begin
							state_q <= ST_SIGN;
						end else begin
							state_q <= ST_DIGS;
						end
					end
				end
				ST_PADL: begin
					strobe_q <= 1'b1;
					pad_q    <= pad_q - 1'b1;
					if (pad_q == 6'd1) begin
						state_q <= neg_q ? ST_SIGN : ST_DIGS;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_DIGS;
				end
				ST_DIGS: begin
					strobe_q <= 1'b1;
					idx_q    <= idx_q - 1'b1;
					if (idx_q == {{(DIG_IDX_W-1){1'b0}}, 1'b1}) begin
						if (ljust_q && pad_q != 6'd0) begin
							state_q <= ST_PADR;
						end else begin
							last_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_PADR: begin
					strobe_q <= 1'b1;
					pad_q    <= pad_q - 1'b1;
					if (pad_q == 6'd1) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working value, options and digit buffer.
	always_ff @(posedge clk) begin
		text_char_q <= char_next;
		if (accept) begin
			neg_q   <= (kind == KIND_SDEC) && value[31];
			val_q   <= ((kind == KIND_SDEC) && value[31]) ? (32'd0 - value) : value;
			ljust_q <= left_justify;
			zfill_q <= zero_fill;
			width_q <= width_sat;
			ctrl_q  <= ctrl_in;
		end else if (state_q == ST_CONV) begin
			val_q       <= quot;
			dig_q[nd_q] <= digit;
		end
	end

	assign strobe    = strobe_q;
	assign text_char = text_char_q;
	assign last      = last_q;

endmodule

/* tb/sv/integer_text_formatter_top_test.sv */
// ----------------------------------------------------------------------------
// Integer text formatter testbench
// Sends integer conversions of every kind, including the spare kind codes,
// through the formatter with bursty start timing. A local model predicts the
// character run of each accepted conversion, and every strobed character is
// compared with it in order.
// ----------------------------------------------------------------------------
module integer_text_formatter_top_test;

	import itf_pkg::*;

	// Spare kind codes, which the formatter treats as unsigned decimal.
	localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

	localparam int RANDOM_ITEMS = 100;
	localparam int DRAIN_CYCLES = 100;

	// One conversion request as it goes onto the input ports.
	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
		logic [5:0]  width;
		logic        zfill;
		logic        ljust;
	} conversion_t;

	// One character of formatted text with its end-of-field flag.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  kind = KIND_SDEC;
	logic [31:0] value = 32'd0;
	logic [5:0]  field_width = 6'd0;
	logic        zero_fill = 1'b0;
	logic        left_justify = 1'b0;
	logic        strobe;
	logic [7:0]  text_char;
	logic        last;

	conversion_t pending_conversions[$];
	char_word_t  expected_chars[$];

	int accepted_count = 0;
	int total_count = 0;
	int directed_count = 0;
	int chars_checked = 0;
	int mismatch_count = 0;
	int burst_left = 4;
	int gap_left = 0;

	integer_text_formatter_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.value        (value),
		.field_width  (field_width),
		.zero_fill    (zero_fill),
		.left_justify (left_justify),
		.strobe       (strobe),
		.text_char    (text_char),
		.last         (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Works out the character run of one conversion and queues it.
	function automatic void format_conversion(input conversion_t c);
		logic [31:0] mag;
		logic [31:0] radix;
		logic [3:0]  d;
		logic [7:0]  ch;
		logic [7:0]  fill;
		logic        neg;
		logic [7:0]  digits[$];
		logic [7:0]  field_text[$];
		int          width;
		int          n_pad;
		mag = c.value;
		neg = 1'b0;
		fill = c.zfill ? CH_ZERO : CH_SPACE;
		radix = 32'd10;
		if (c.kind == KIND_OCT) begin
			radix = 32'd8;
		end else if (c.kind == KIND_HEXL || c.kind == KIND_HEXU) begin
			radix = 32'd16;
		end
		// The most negative value comes out right as an unsigned magnitude.
		if (c.kind == KIND_SDEC && mag[31]) begin
			neg = 1'b1;
			mag = 32'd0 - mag;
		end
		do begin
			d = 4'(mag % radix);
			if (d < 4'd10) begin
				ch = CH_ZERO + 8'(d);
			end else if (c.kind == KIND_HEXU) begin
				ch = CH_UPPER_A + 8'(d) - 8'd10;
			end else begin
				ch = CH_LOWER_A + 8'(d) - 8'd10;
			end
			digits.push_front(ch);
			mag = mag / radix;
		end while (mag != 32'd0);

		width = int'(c.width);
		if (width > MAX_WIDTH) begin
			width = MAX_WIDTH;
		end
		n_pad = width - (digits.size() + (neg ? 1 : 0));
		if (n_pad < 0) begin
			n_pad = 0;
		end

		// Fill goes ahead of the sign when right justified.
		if (!c.ljust) begin
			for (int i = 0; i < n_pad; i++) begin
				field_text.push_back(fill);
			end
		end
		if (neg) begin
			field_text.push_back(CH_MINUS);
		end
		foreach (digits[i]) begin
			field_text.push_back(digits[i]);
		end
		if (c.ljust) begin
			for (int i = 0; i < n_pad; i++) begin
				field_text.push_back(fill);
			end
		end
		foreach (field_text[i]) begin
			expected_chars.push_back('{ch: field_text[i], last: i == field_text.size() - 1});
		end
	endfunction

	task automatic add_conversion(input logic [2:0] k, input logic [31:0] v,
			input logic [5:0] w, input logic zf, input logic lj);
		pending_conversions.push_back('{kind: k, value: v, width: w, zfill: zf, ljust: lj});
	endtask

	// Random conversion, leaning on small widths and on sign edges.
	function automatic conversion_t random_conversion();
		conversion_t c;
		if ($urandom_range(0, 9) == 0) begin
			c.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
		end else begin
			c.kind = 3'($urandom_range(KIND_SDEC, KIND_HEXU));
		end
		case ($urandom_range(0, 4))
			0: begin
				c.value = $urandom;
			end
			1: begin
				c.value = $urandom_range(0, 99);
			end
			2: begin
				c.value = 32'd0 - $urandom_range(1, 1000);
			end
			3: begin
				c.value = {1'b1, 31'($urandom)};
			end
			default: begin
				c.value = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
			end
		endcase
		if ($urandom_range(0, 7) == 0) begin
			c.width = 6'($urandom_range(32, 63));
		end else begin
			c.width = 6'($urandom_range(0, 16));
		end
		c.zfill = 1'($urandom_range(0, 1));
		c.ljust = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Driver: presents words in bursts and predicts each one as it is taken.
	always @(posedge clk) begin : driver
		conversion_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				format_conversion('{kind: kind, value: value, width: field_width,
					zfill: zero_fill, ljust: left_justify});
				accepted_count++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_conversions.size() > 0) begin
					nxt = pending_conversions.pop_front();
					kind <= nxt.kind;
					value <= nxt.value;
					field_width <= nxt.width;
					zero_fill <= nxt.zfill;
					left_justify <= nxt.ljust;
					start <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						// Sometimes a long burst next, and sometimes no gap at all before it.
						burst_left = ($urandom_range(0, 5) == 0) ? 20 : $urandom_range(1, 6);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed word must match the oldest expected character.
	always @(posedge clk) begin : monitor
		char_word_t want;
		if (arst_n && strobe) begin
			chars_checked++;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 0x%02h", text_char));
			end else begin
				want = expected_chars.pop_front();
				if (text_char !== want.ch) begin
					report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
						text_char, want.ch));
				end
				if (last !== want.last) begin
					report_mismatch($sformatf("last %b, expected %b", last, want.last));
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Directed corners: signs, extremes, fill placement and spare kinds.
		add_conversion(KIND_SDEC, 32'd0, 6'd0, 1'b0, 1'b0);
		add_conversion(KIND_SDEC, 32'hFFFF_FFFB, 6'd5, 1'b1, 1'b0);
		add_conversion(KIND_SDEC, 32'hFFFF_FFFB, 6'd5, 1'b1, 1'b1);
		add_conversion(KIND_SDEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0);
		add_conversion(KIND_SDEC, 32'h7FFF_FFFF, 6'd0, 1'b0, 1'b0);
		add_conversion(KIND_SDEC, 32'hFFFF_FFFF, 6'd2, 1'b0, 1'b0);
		add_conversion(KIND_SDEC, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1);
		add_conversion(KIND_SDEC, 32'h8000_0000, 6'd20, 1'b0, 1'b1);
		add_conversion(KIND_UDEC, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0);
		add_conversion(KIND_UDEC, 32'h8000_0000, 6'd10, 1'b1, 1'b0);
		add_conversion(KIND_UDEC, 32'd0, 6'd63, 1'b0, 1'b1);
		add_conversion(KIND_OCT, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0);
		add_conversion(KIND_OCT, 32'd8, 6'd1, 1'b0, 1'b0);
		add_conversion(KIND_OCT, 32'o1234567, 6'd11, 1'b1, 1'b1);
		add_conversion(KIND_HEXL, 32'hDEAD_BEEF, 6'd12, 1'b0, 1'b0);
		add_conversion(KIND_HEXL, 32'd0, 6'd63, 1'b1, 1'b0);
		add_conversion(KIND_HEXU, 32'hDEAD_BEEF, 6'd12, 1'b0, 1'b1);
		add_conversion(KIND_HEXU, 32'hABCD_EF01, 6'd8, 1'b1, 1'b0);
		add_conversion(KIND_HEXU, 32'h0000_00FA, 6'd31, 1'b1, 1'b0);
		for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
			add_conversion(3'(k), 32'hFFFF_FFF6, 6'd3, 1'b0, 1'b0);
		end
		add_conversion(KIND_SPARE_FIRST, 32'd12345, 6'd42, 1'b1, 1'b1);
		directed_count = pending_conversions.size();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pending_conversions.push_back(random_conversion());
		end
		total_count = pending_conversions.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_count) begin
			@(posedge clk);
		end
		while (expected_chars.size() != 0) begin
			@(posedge clk);
		end
		// Catch any stray characters after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d conversions (%0d directed, %0d random) over all kinds and fills,",
			total_count, directed_count, total_count - directed_count);
		$display("checked %0d characters, %0d mismatches.", chars_checked, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("run timed out with %0d of %0d conversions accepted",
			accepted_count, total_count);
		$display("FAIL");
		$finish;
	end

endmodule
